[sv/i2cebm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cebm_pkg
// Types and constants for the I2C EEPROM byte master.
// ----------------------------------------------------------------------------
package i2cebm_pkg;

    localparam int unsigned ADDR_W     = 17;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam logic [BYTE_W-1:0] RST_DEV_CODE  = 8'hA0;
    localparam logic [BYTE_W-1:0] RST_PAGE_BITS = 8'h02;
    localparam logic [BYTE_W-1:0] RST_POLL_LIM  = 8'd100;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_RSVD  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEV_CODE  = 2'd0,
        CFG_PAGE_BITS = 2'd1,
        CFG_POLL_LIM  = 2'd2,
        CFG_NONE      = 2'd3
    } t_cfg_idx;

    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_START   = 16'h0002,
        ST_TXDEV   = 16'h0004,
        ST_ACK1    = 16'h0008,
        ST_TXHI    = 16'h0010,
        ST_ACK2    = 16'h0020,
        ST_TXLO    = 16'h0040,
        ST_ACK3    = 16'h0080,
        ST_TXDATA  = 16'h0100,
        ST_ACK4    = 16'h0200,
        ST_STOP    = 16'h0400,
        ST_RESTART = 16'h0800,
        ST_TXDEVR  = 16'h1000,
        ST_ACK5    = 16'h2000,
        ST_RX      = 16'h4000,
        ST_NOACK   = 16'h8000
    } t_stage;

    typedef enum logic [1:0] {
        SUB_0 = 2'd0,
        SUB_1 = 2'd1,
        SUB_2 = 2'd2,
        SUB_3 = 2'd3
    } t_sub;

endpackage
`default_nettype wire

[sv/i2c_eeprom_byte_master.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master
// I2C master for a single-byte write or a random read of a 17-bit EEPROM
// address, advanced by one bus phase per input beat.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  in        sink       i_in_valid / o_in_stall      opcode, address, data, sda
//  out       source     o_out_valid / i_out_stall    scl, sda, wp, busy, done, rd
//  cfg       sink       i_cfg_valid / o_cfg_ready    index, data
//
//  one input beat per clock unless the output stalls, each giving one registered result beat
//  the phase sequencer and the output register set the rate; no other stage
//  an input beat is taken whenever the output register is empty or drains
//  reset is synchronous and returns the sequencer to idle with wp high
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master
    import i2cebm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [ADDR_W-1:0]    i_mem_address,
    input  wire logic [BYTE_W-1:0]    i_write_data,
    input  wire logic                 i_sda_in,

    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_scl_level,
    output logic                      o_sda_release,
    output logic                      o_write_protect,
    output logic                      o_busy_res,
    output logic                      o_done_res,
    output logic [BYTE_W-1:0]         o_read_data,

    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data
);

    logic [BYTE_W-1:0] r_dev_code;
    logic [BYTE_W-1:0] r_page_bits;
    logic [BYTE_W-1:0] r_poll_lim;

    t_stage            r_stage, n_stage;
    logic [1:0]        r_sub, n_sub;
    logic [3:0]        r_bit, n_bit;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic [BYTE_W-1:0] r_ack, n_ack;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [BYTE_W-1:0] r_data, n_data;
    logic              r_is_read, n_is_read;
    logic              r_wp, n_wp;

    logic              r_out_valid, n_out_valid;
    logic              r_scl, n_scl;
    logic              r_sdo, n_sdo;
    logic              r_wp_out, n_wp_out;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [BYTE_W-1:0] r_rd, n_rd;

    logic              in_accept;
    logic              v_bad;
    logic              v_enter;
    t_stage            v_tgt;
    logic [BYTE_W-1:0] v_dev;

    function automatic t_stage next_stage(input t_stage s, input logic is_rd);
        t_stage nxt;
        case (s)
            ST_START:   nxt = ST_TXDEV;
            ST_TXDEV:   nxt = ST_ACK1;
            ST_ACK1:    nxt = ST_TXHI;
            ST_TXHI:    nxt = ST_ACK2;
            ST_ACK2:    nxt = ST_TXLO;
            ST_TXLO:    nxt = ST_ACK3;
            ST_ACK3:    nxt = is_rd ? ST_RESTART : ST_TXDATA;
            ST_TXDATA:  nxt = ST_ACK4;
            ST_ACK4:    nxt = ST_STOP;
            ST_RESTART: nxt = ST_TXDEVR;
            ST_TXDEVR:  nxt = ST_ACK5;
            ST_ACK5:    nxt = ST_RX;
            ST_RX:      nxt = ST_NOACK;
            ST_NOACK:   nxt = ST_STOP;
            default:    nxt = ST_IDLE;
        endcase
        return nxt;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;

    assign o_out_valid     = r_out_valid;
    assign o_scl_level     = r_scl;
    assign o_sda_release   = r_sdo;
    assign o_write_protect = r_wp_out;
    assign o_busy_res      = r_busy;
    assign o_done_res      = r_done;
    assign o_read_data     = r_rd;

    always_comb begin
        n_stage   = r_stage;
        n_sub     = r_sub;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_ack     = r_ack;
        n_addr    = r_addr;
        n_data    = r_data;
        n_is_read = r_is_read;
        n_wp_out  = r_wp;
        v_bad     = 1'b0;
        v_enter   = 1'b0;
        v_tgt     = ST_IDLE;
        n_scl     = 1'b1;
        n_sdo     = 1'b1;
        n_busy    = 1'b1;
        n_done    = 1'b0;
        n_rd      = '0;

        // command pickup when idle
        if (r_stage == ST_IDLE) begin
            if (i_opcode == OP_WRITE || i_opcode == OP_READ) begin
                n_addr    = i_mem_address;
                n_data    = i_write_data;
                n_is_read = (i_opcode == OP_READ);
                if (i_opcode == OP_WRITE) begin
                    n_wp_out = 1'b0;
                end
                n_stage = ST_START;
                n_sub   = SUB_0;
                n_bit   = '0;
                n_ack   = '0;
            end else begin
                v_bad = 1'b1;
            end
        end

        if (!v_bad) begin
            case (n_stage)
                ST_START: begin
                    case (n_sub)
                        SUB_0: begin n_scl = 1'b1; n_sdo = 1'b1; n_sub = SUB_1; end
                        SUB_1: begin n_scl = 1'b1; n_sdo = 1'b0; n_sub = SUB_2; end
                        SUB_2: begin
                            n_scl = 1'b0; n_sdo = 1'b0;
                            v_enter = 1'b1; v_tgt = ST_TXDEV;
                        end
                        default: v_bad = 1'b1;
                    endcase
                end
                ST_RESTART: begin
                    case (n_sub)
                        SUB_0: begin n_scl = 1'b0; n_sdo = 1'b1; n_sub = SUB_1; end
                        SUB_1: begin n_scl = 1'b1; n_sdo = 1'b1; n_sub = SUB_2; end
                        SUB_2: begin n_scl = 1'b1; n_sdo = 1'b0; n_sub = SUB_3; end
                        default: begin
                            n_scl = 1'b0; n_sdo = 1'b0;
                            v_enter = 1'b1; v_tgt = ST_TXDEVR;
                        end
                    endcase
                end
                ST_TXDEV, ST_TXHI, ST_TXLO, ST_TXDATA, ST_TXDEVR: begin
                    case (n_sub)
                        SUB_0: begin n_scl = 1'b0; n_sdo = n_shift[7]; n_sub = SUB_1; end
                        SUB_1: begin
                            n_scl   = 1'b1;
                            n_sdo   = n_shift[7];
                            n_shift = {n_shift[BYTE_W-2:0], 1'b0};
                            n_bit   = n_bit + 4'd1;
                            if (n_bit >= BITS_PER_BYTE) begin
                                v_enter = 1'b1;
                                v_tgt   = next_stage(n_stage, n_is_read);
                            end else begin
                                n_sub = SUB_0;
                            end
                        end
                        default: v_bad = 1'b1;
                    endcase
                end
                ST_ACK1, ST_ACK2, ST_ACK3, ST_ACK4, ST_ACK5: begin
                    case (n_sub)
                        SUB_0: begin
                            n_scl = 1'b0; n_sdo = 1'b1; n_ack = '0; n_sub = SUB_1;
                        end
                        SUB_1: begin
                            n_scl = 1'b1; n_sdo = 1'b1;
                            if (!i_sda_in || n_ack >= r_poll_lim) begin
                                v_enter = 1'b1;
                                v_tgt   = next_stage(n_stage, n_is_read);
                            end else begin
                                n_ack = n_ack + 8'd1;
                            end
                        end
                        default: v_bad = 1'b1;
                    endcase
                end
                ST_RX: begin
                    case (n_sub)
                        SUB_0: begin n_scl = 1'b0; n_sdo = 1'b1; n_sub = SUB_1; end
                        SUB_1: begin
                            n_scl   = 1'b1;
                            n_sdo   = 1'b1;
                            n_shift = {n_shift[BYTE_W-2:0], i_sda_in};
                            n_bit   = n_bit + 4'd1;
                            if (n_bit >= BITS_PER_BYTE) begin
                                v_enter = 1'b1; v_tgt = ST_NOACK;
                            end else begin
                                n_sub = SUB_0;
                            end
                        end
                        default: v_bad = 1'b1;
                    endcase
                end
                ST_NOACK: begin
                    case (n_sub)
                        SUB_0: begin n_scl = 1'b0; n_sdo = 1'b1; n_sub = SUB_1; end
                        SUB_1: begin
                            n_scl = 1'b1; n_sdo = 1'b1;
                            v_enter = 1'b1; v_tgt = ST_STOP;
                        end
                        default: v_bad = 1'b1;
                    endcase
                end
                ST_STOP: begin
                    case (n_sub)
                        SUB_0: begin n_scl = 1'b0; n_sdo = 1'b0; n_sub = SUB_1; end
                        SUB_1: begin n_scl = 1'b1; n_sdo = 1'b0; n_sub = SUB_2; end
                        SUB_2: begin
                            n_scl  = 1'b1;
                            n_sdo  = 1'b1;
                            n_done = 1'b1;
                            if (n_is_read) begin
                                n_rd = n_shift;
                            end
                            n_stage = ST_IDLE;
                            n_sub   = SUB_0;
                        end
                        default: v_bad = 1'b1;
                    endcase
                end
                default: v_bad = 1'b1;
            endcase
        end

        // entry to a new stage, loading the byte to send
        v_dev = r_dev_code | (n_addr[ADDR_W-1] ? r_page_bits : '0);
        if (v_enter) begin
            n_stage = v_tgt;
            n_sub   = SUB_0;
            n_bit   = '0;
            n_ack   = '0;
            case (v_tgt)
                ST_TXDEV:  n_shift = v_dev;
                ST_TXHI:   n_shift = n_addr[15:8];
                ST_TXLO:   n_shift = n_addr[7:0];
                ST_TXDATA: n_shift = n_data;
                ST_TXDEVR: n_shift = v_dev + 8'd1;
                ST_RX:     n_shift = '0;
                default:   n_shift = n_shift;
            endcase
        end

        // idle beat or bad phase code
        if (v_bad) begin
            if (n_stage != ST_IDLE) begin
                n_stage  = ST_IDLE;
                n_sub    = SUB_0;
                n_wp_out = 1'b1;
            end
            n_scl  = 1'b1;
            n_sdo  = 1'b1;
            n_busy = 1'b0;
            n_done = 1'b0;
            n_rd   = '0;
        end

        n_wp = n_done ? 1'b1 : n_wp_out;
    end

    always_comb begin
        if (in_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_code  <= RST_DEV_CODE;
            r_page_bits <= RST_PAGE_BITS;
            r_poll_lim  <= RST_POLL_LIM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEV_CODE:  r_dev_code  <= i_cfg_data;
                CFG_PAGE_BITS: r_page_bits <= i_cfg_data;
                CFG_POLL_LIM:  r_poll_lim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_IDLE;
            r_sub       <= SUB_0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_ack       <= '0;
            r_addr      <= '0;
            r_data      <= '0;
            r_is_read   <= 1'b0;
            r_wp        <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_accept) begin
                r_stage   <= n_stage;
                r_sub     <= n_sub;
                r_bit     <= n_bit;
                r_shift   <= n_shift;
                r_ack     <= n_ack;
                r_addr    <= n_addr;
                r_data    <= n_data;
                r_is_read <= n_is_read;
                r_wp      <= n_wp;
            end
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_scl    <= n_scl;
            r_sdo    <= n_sdo;
            r_wp_out <= n_wp_out;
            r_busy   <= n_busy;
            r_done   <= n_done;
            r_rd     <= n_rd;
        end
    end

endmodule
`default_nettype wire

[sim/i2cebm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cebm_bus_checker
// Watches the input, output and register channels of the I2C EEPROM byte
// master. It keeps its own copy of the bus sequencer and registers, predicts
// the line levels for every input beat and compares each output beat, in
// order, against the oldest prediction.
// ----------------------------------------------------------------------------
module i2cebm_bus_checker
    import i2cebm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [ADDR_W-1:0]    i_mem_address,
    input  wire logic [BYTE_W-1:0]    i_write_data,
    input  wire logic                 i_sda_in,

    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic                 i_scl_level,
    input  wire logic                 i_sda_release,
    input  wire logic                 i_write_protect,
    input  wire logic                 i_busy_res,
    input  wire logic                 i_done_res,
    input  wire logic [BYTE_W-1:0]    i_read_data,

    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,

    output int                        o_fail_count,
    output int                        o_pending,
    output logic                      o_bus_idle
);

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              wp;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rd;
    } bus_beat_t;

    bus_beat_t         expected_beats[$];
    int                errs = 0;

    logic [BYTE_W-1:0] dev_code;
    logic [BYTE_W-1:0] page_or;
    logic [BYTE_W-1:0] poll_lim;

    t_stage            stg;
    t_sub              sub;
    logic [3:0]        nbits;
    logic [BYTE_W-1:0] shreg;
    logic [BYTE_W-1:0] ack_cnt;
    logic [ADDR_W-1:0] hold_addr;
    logic [BYTE_W-1:0] hold_data;
    logic              rd_mode;
    logic              wp_lvl;

    function automatic logic [BYTE_W-1:0] dev_byte();
        return dev_code | (hold_addr[16] ? page_or : 8'h00);
    endfunction

    function automatic t_stage stage_after(input t_stage s);
        case (s)
            ST_ACK3:          return rd_mode ? ST_RESTART : ST_TXDATA;
            ST_ACK4, ST_NOACK: return ST_STOP;
            ST_STOP:          return ST_IDLE;
            default:          return t_stage'({s[14:0], 1'b0});
        endcase
    endfunction

    task automatic enter_stage(input t_stage s);
        stg     = s;
        sub     = SUB_0;
        nbits   = '0;
        ack_cnt = '0;
        case (s)
            ST_TXDEV:  shreg = dev_byte();
            ST_TXHI:   shreg = hold_addr[15:8];
            ST_TXLO:   shreg = hold_addr[7:0];
            ST_TXDATA: shreg = hold_data;
            ST_TXDEVR: shreg = dev_byte() + 8'd1;
            ST_RX:     shreg = '0;
            default: ;
        endcase
    endtask

    task automatic predict_beat(input t_opcode op, input logic [ADDR_W-1:0] a,
                                input logic [BYTE_W-1:0] d, input logic s,
                                output bus_beat_t r);
        logic bad;
        logic msb;
        r   = '{scl: 1'b1, sda: 1'b1, wp: 1'b1, busy: 1'b1, done: 1'b0, rd: '0};
        bad = 1'b0;
        if (stg == ST_IDLE) begin
            if (op == OP_WRITE || op == OP_READ) begin
                hold_addr = a;
                hold_data = d;
                rd_mode   = (op == OP_READ);
                if (!rd_mode) begin
                    wp_lvl = 1'b0;
                end
                enter_stage(ST_START);
            end else begin
                bad = 1'b1;
            end
        end
        msb = shreg[7];
        if (!bad) begin
            case (stg)
                ST_START: begin
                    case (sub)
                        SUB_0: begin r.scl = 1'b1; r.sda = 1'b1; sub = SUB_1; end
                        SUB_1: begin r.scl = 1'b1; r.sda = 1'b0; sub = SUB_2; end
                        SUB_2: begin r.scl = 1'b0; r.sda = 1'b0; enter_stage(ST_TXDEV); end
                        default: bad = 1'b1;
                    endcase
                end
                ST_RESTART: begin
                    case (sub)
                        SUB_0: begin r.scl = 1'b0; r.sda = 1'b1; sub = SUB_1; end
                        SUB_1: begin r.scl = 1'b1; r.sda = 1'b1; sub = SUB_2; end
                        SUB_2: begin r.scl = 1'b1; r.sda = 1'b0; sub = SUB_3; end
                        default: begin r.scl = 1'b0; r.sda = 1'b0; enter_stage(ST_TXDEVR); end
                    endcase
                end
                ST_TXDEV, ST_TXHI, ST_TXLO, ST_TXDATA, ST_TXDEVR: begin
                    case (sub)
                        SUB_0: begin r.scl = 1'b0; r.sda = msb; sub = SUB_1; end
                        SUB_1: begin
                            r.scl = 1'b1;
                            r.sda = msb;
                            shreg = {shreg[6:0], 1'b0};
                            nbits = nbits + 4'd1;
                            if (nbits >= BITS_PER_BYTE) begin
                                enter_stage(stage_after(stg));
                            end else begin
                                sub = SUB_0;
                            end
                        end
                        default: bad = 1'b1;
                    endcase
                end
                ST_ACK1, ST_ACK2, ST_ACK3, ST_ACK4, ST_ACK5: begin
                    case (sub)
                        SUB_0: begin
                            r.scl   = 1'b0;
                            r.sda   = 1'b1;
                            ack_cnt = '0;
                            sub     = SUB_1;
                        end
                        SUB_1: begin
                            r.scl = 1'b1;
                            r.sda = 1'b1;
                            if (!s || ack_cnt >= poll_lim) begin
                                enter_stage(stage_after(stg));
                            end else begin
                                ack_cnt = ack_cnt + 8'd1;
                            end
                        end
                        default: bad = 1'b1;
                    endcase
                end
                ST_RX: begin
                    case (sub)
                        SUB_0: begin r.scl = 1'b0; r.sda = 1'b1; sub = SUB_1; end
                        SUB_1: begin
                            r.scl = 1'b1;
                            r.sda = 1'b1;
                            shreg = {shreg[6:0], s};
                            nbits = nbits + 4'd1;
                            if (nbits >= BITS_PER_BYTE) begin
                                enter_stage(ST_NOACK);
                            end else begin
                                sub = SUB_0;
                            end
                        end
                        default: bad = 1'b1;
                    endcase
                end
                ST_NOACK: begin
                    case (sub)
                        SUB_0: begin r.scl = 1'b0; r.sda = 1'b1; sub = SUB_1; end
                        SUB_1: begin r.scl = 1'b1; r.sda = 1'b1; enter_stage(ST_STOP); end
                        default: bad = 1'b1;
                    endcase
                end
                ST_STOP: begin
                    case (sub)
                        SUB_0: begin r.scl = 1'b0; r.sda = 1'b0; sub = SUB_1; end
                        SUB_1: begin r.scl = 1'b1; r.sda = 1'b0; sub = SUB_2; end
                        SUB_2: begin
                            r.scl  = 1'b1;
                            r.sda  = 1'b1;
                            r.done = 1'b1;
                            r.rd   = rd_mode ? shreg : 8'h00;
                            stg    = ST_IDLE;
                            sub    = SUB_0;
                        end
                        default: bad = 1'b1;
                    endcase
                end
                default: bad = 1'b1;
            endcase
        end
        if (bad) begin
            if (stg != ST_IDLE) begin
                stg    = ST_IDLE;
                sub    = SUB_0;
                wp_lvl = 1'b1;
            end
            r.scl  = 1'b1;
            r.sda  = 1'b1;
            r.busy = 1'b0;
            r.done = 1'b0;
            r.rd   = '0;
        end
        r.wp = wp_lvl;
        if (r.done) begin
            wp_lvl = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            errs++;
            if (errs <= 100) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        bus_beat_t exp_beat;
        bus_beat_t got_beat;
        if (!i_rst_n) begin
            expected_beats.delete();
            dev_code  = RST_DEV_CODE;
            page_or   = RST_PAGE_BITS;
            poll_lim  = RST_POLL_LIM;
            stg       = ST_IDLE;
            sub       = SUB_0;
            nbits     = '0;
            shreg     = '0;
            ack_cnt   = '0;
            hold_addr = '0;
            hold_data = '0;
            rd_mode   = 1'b0;
            wp_lvl    = 1'b1;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DEV_CODE:  dev_code = i_cfg_data;
                    CFG_PAGE_BITS: page_or  = i_cfg_data;
                    CFG_POLL_LIM:  poll_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_beat(t_opcode'(i_opcode), i_mem_address, i_write_data, i_sda_in,
                             exp_beat);
                expected_beats.push_back(exp_beat);
            end
            if (i_out_valid && !i_out_stall) begin
                got_beat = '{scl: i_scl_level, sda: i_sda_release, wp: i_write_protect,
                             busy: i_busy_res, done: i_done_res, rd: i_read_data};
                if (expected_beats.size() == 0) begin
                    errs++;
                    if (errs <= 100) begin
                        $display("%0t: unexpected result beat, expected none, got %h",
                                 $time, got_beat);
                    end
                end else begin
                    exp_beat = expected_beats.pop_front();
                    check_field("scl_level", 8'(exp_beat.scl), 8'(got_beat.scl));
                    check_field("sda_release", 8'(exp_beat.sda), 8'(got_beat.sda));
                    check_field("write_protect", 8'(exp_beat.wp), 8'(got_beat.wp));
                    check_field("busy_res", 8'(exp_beat.busy), 8'(got_beat.busy));
                    check_field("done_res", 8'(exp_beat.done), 8'(got_beat.done));
                    check_field("read_data", exp_beat.rd, got_beat.rd);
                end
            end
        end
        o_fail_count <= errs;
        o_pending    <= expected_beats.size();
        o_bus_idle   <= (stg == ST_IDLE);
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the I2C EEPROM byte master with whole write and read transfers,
// stray commands and idle ticks under random input gaps and output stalls,
// across several register settings. The checker beside the block predicts
// and compares every result beat; this module only reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    import i2cebm_pkg::*;

    localparam int WDOG_LIMIT = 4000;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [1:0]           opcode    = OP_TICK;
    logic [ADDR_W-1:0]    addr      = '0;
    logic [BYTE_W-1:0]    wdata     = '0;
    logic                 sda       = 1'b1;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_DEV_CODE;
    logic [BYTE_W-1:0]    cfg_data  = '0;

    wire logic              in_stall;
    wire logic              out_valid;
    wire logic              scl;
    wire logic              sda_rel;
    wire logic              wp;
    wire logic              busy;
    wire logic              done;
    wire logic [BYTE_W-1:0] rd_data;
    wire logic              cfg_ready;

    int   fail_count;
    int   pending;
    logic bus_idle;

    int   burst_left  = 0;
    int   sda_low_pct = 50;
    bit   last_cmd    = 1'b0;
    int   stall_mode  = 0;
    int   stall_left  = 0;
    int   cyc         = 0;
    int   quiet       = 0;

    i2c_eeprom_byte_master u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_opcode        (opcode),
        .i_mem_address   (addr),
        .i_write_data    (wdata),
        .i_sda_in        (sda),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_scl_level     (scl),
        .o_sda_release   (sda_rel),
        .o_write_protect (wp),
        .o_busy_res      (busy),
        .o_done_res      (done),
        .o_read_data     (rd_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    i2cebm_bus_checker u_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_opcode        (opcode),
        .i_mem_address   (addr),
        .i_write_data    (wdata),
        .i_sda_in        (sda),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_scl_level     (scl),
        .i_sda_release   (sda_rel),
        .i_write_protect (wp),
        .i_busy_res      (busy),
        .i_done_res      (done),
        .i_read_data     (rd_data),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bus_idle      (bus_idle)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern
    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= cyc[2];
        endcase
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= WDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'($urandom());
    endfunction

    function automatic logic rand_sda();
        return ($urandom_range(0, 99) >= sda_low_pct);
    endfunction

    function automatic t_opcode tick_op(input int noise_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < noise_pct) begin
            return $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        end
        if (r < noise_pct + 5) begin
            return OP_RSVD;
        end
        return OP_TICK;
    endfunction

    task automatic send_beat(input t_opcode op, input logic [ADDR_W-1:0] a,
                             input logic [BYTE_W-1:0] d, input logic s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode   <= op;
        addr     <= a;
        wdata    <= d;
        sda      <= s;
        last_cmd  = (op == OP_WRITE || op == OP_READ);
        do @(posedge clk); while (in_stall);
    endtask

    // one command, then ticks, reserved opcodes and stray commands until the sequencer is back in idle
    task automatic run_xfer(input t_opcode op, input logic [ADDR_W-1:0] a,
                            input logic [BYTE_W-1:0] d, input int noise_pct);
        send_beat(op, a, d, rand_sda());
        do begin
            send_beat(tick_op(noise_pct), rand_addr(), BYTE_W'($urandom()), rand_sda());
        end while (!bus_idle || last_cmd);
    endtask

    task automatic settle();
        while (!bus_idle || last_cmd) begin
            send_beat(OP_TICK, rand_addr(), BYTE_W'($urandom()), rand_sda());
        end
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] dev, input logic [BYTE_W-1:0] page,
                              input logic [BYTE_W-1:0] lim);
        logic [BYTE_W-1:0] vals[4];
        vals = '{dev, page, lim, BYTE_W'($urandom())};
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_idx   <= t_cfg_idx'(k);
            cfg_data  <= vals[k];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int ph;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // idle ticks, reserved opcode, then transfers at the reset settings
        sda_low_pct = 100;
        send_beat(OP_TICK, '0, '0, 1'b0);
        send_beat(OP_RSVD, '1, '1, 1'b1);
        send_beat(OP_TICK, '1, '1, 1'b1);
        run_xfer(OP_WRITE, 17'h1FFFF, 8'hFF, 0);
        sda_low_pct = 50;
        run_xfer(OP_READ, 17'h00000, 8'h00, 0);
        // stray commands while busy
        run_xfer(OP_READ, 17'h0FFFF, 8'h5A, 25);
        settle();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_config(8'hFE, 8'hFF, 8'd0);
                1: set_config(8'h00, 8'h00, 8'd255);
                2: set_config(8'hA0, 8'h01, 8'd1);
                default: set_config(BYTE_W'($urandom_range(0, 127) * 2), BYTE_W'($urandom()),
                                    BYTE_W'($urandom_range(0, 6)));
            endcase
            // no ack except at the largest limit, so short polls run out
            sda_low_pct = (ph == 1) ? 50 : 0;
            run_xfer(ph[0] ? OP_WRITE : OP_READ, rand_addr() | 17'h10000,
                     BYTE_W'($urandom()), 0);
            case ($urandom_range(0, 2))
                0:       sda_low_pct = 15;
                1:       sda_low_pct = 50;
                default: sda_low_pct = 85;
            endcase
            for (n = 0; n < 70; n++) begin
                if (bus_idle && !last_cmd && $urandom_range(0, 99) < 60) begin
                    send_beat($urandom_range(0, 1) ? OP_WRITE : OP_READ, rand_addr(),
                              BYTE_W'($urandom()), rand_sda());
                end else begin
                    send_beat(tick_op(4), rand_addr(), BYTE_W'($urandom()), rand_sda());
                end
            end
            settle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
